FILE: rtl/core/ave_pkg.sv
// shared types, constants and the arctangent table for the aim vector angle unit
`timescale 1ns / 1ps
package ave_pkg;

  localparam int COORD_BITS = 32;
  localparam int ANGLE_BITS = 18;
  localparam int ZROT_BITS  = 17;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MAG_W      = 30;
  localparam int SD_W       = MAG_W + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int RES_W      = SUM_W + 1;
  localparam int ROOT_W     = 31;
  localparam int SQRT_STEPS = 31;
  localparam int CX_W       = 35;
  localparam int CZ_W       = 34;
  localparam int ANG_SH     = 32 - ANGLE_BITS;

  // gamma = round(zr * 2^ANGLE_BITS / 36000) = floor((|zr| * 2^(ANGLE_BITS-4) + 1125) / 2250)
  localparam int GAM_SHL  = ANGLE_BITS - 4;
  localparam int GAM_A_W  = ZROT_BITS + GAM_SHL;
  localparam int GAM_DIV  = 2250;
  localparam int GAM_BIAS = 1125;
  localparam int GAM_K    = 42;
  localparam longint GAM_M = (64'd1 << GAM_K) / GAM_DIV;
  localparam int GAM_P_W  = 2 * GAM_A_W;
  localparam int GAM_Q_W  = 20;

  typedef struct packed {
    logic signed [SD_W-1:0]  dx;
    logic signed [SD_W-1:0]  dy;
    logic signed [SD_W-1:0]  dz;
    logic [ANGLE_BITS-1:0]   gamma;
    logic                    deg;
    logic                    xz_zero;
  } side_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] gamma;
    logic                  deg;
    logic                  xz_zero;
  } cside_t;

  // atan(2^-i) in 2^32 units per turn, truncated
  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051D;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2F9;
      5'd15: t = 32'h0000517C;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A2F;
      5'd19: t = 32'h00000517;
      5'd20: t = 32'h0000028B;
      5'd21: t = 32'h00000145;
      5'd22: t = 32'h000000A2;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000028;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000002;
      5'd29: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/ave_prep.sv
// front pipeline: differences, normalization, squares and the gamma conversion
`timescale 1ns / 1ps
module ave_prep (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ave_pkg::COORD_BITS-1:0] origin_x,
  input  logic signed [ave_pkg::COORD_BITS-1:0] origin_y,
  input  logic signed [ave_pkg::COORD_BITS-1:0] origin_z,
  input  logic signed [ave_pkg::COORD_BITS-1:0] aim_x,
  input  logic signed [ave_pkg::COORD_BITS-1:0] aim_y,
  input  logic signed [ave_pkg::COORD_BITS-1:0] aim_z,
  input  logic signed [ave_pkg::ZROT_BITS-1:0]  z_rotation,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ave_pkg::side_t                        out_side,
  output logic [ave_pkg::SUM_W-1:0]             out_sum
);

  localparam int DW = ave_pkg::DIFF_W;
  localparam int MW = ave_pkg::MAG_W;
  localparam int SW = ave_pkg::SD_W;
  localparam int AW = ave_pkg::GAM_A_W;
  localparam int PW = ave_pkg::GAM_P_W;
  localparam int QW = ave_pkg::GAM_Q_W;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1
  logic [DW-1:0] mag_nxt [3];
  logic [2:0]    neg_nxt;
  logic [DW-1:0] mag1_r [3];
  logic [2:0]    neg1_r;
  logic          deg1_r;
  logic [AW-1:0] a1_r;
  logic          gneg1_r;
  logic [ave_pkg::ZROT_BITS-1:0] zabs;

  // stage 2
  logic [SW-1:0] sd2_r [3];
  logic [MW-1:0] mx2_r, mz2_r;
  logic          deg2_r, xzz2_r, gneg2_r;
  logic [AW-1:0] a2_r;
  logic [PW-1:0] p2_r;

  // stage 3
  logic [SW-1:0] sd3_r [3];
  logic [ave_pkg::SQ_W-1:0] sqx3_r, sqz3_r;
  logic          deg3_r, xzz3_r, gneg3_r;
  logic [QW-1:0] q3_r;

  // stage 4
  ave_pkg::side_t           side4_r;
  logic [ave_pkg::SUM_W-1:0] sum4_r;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    logic signed [DW-1:0] d [3];
    d[0] = DW'(aim_x) - DW'(origin_x);
    d[1] = DW'(aim_y) - DW'(origin_y);
    d[2] = DW'(aim_z) - DW'(origin_z);
    for (int k = 0; k < 3; k++) begin
      neg_nxt[k] = d[k][DW-1];
      mag_nxt[k] = d[k][DW-1] ? (~d[k] + DW'(1)) : d[k];
    end
    zabs = z_rotation[ave_pkg::ZROT_BITS-1] ? (~z_rotation + 1'b1) : z_rotation;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1) begin
      mag1_r  <= mag_nxt;
      neg1_r  <= neg_nxt;
      deg1_r  <= (mag_nxt[0] | mag_nxt[1] | mag_nxt[2]) == '0;
      a1_r    <= {zabs, ave_pkg::GAM_SHL'(0)} + AW'(ave_pkg::GAM_BIAS);
      gneg1_r <= z_rotation[ave_pkg::ZROT_BITS-1];
    end
  end

  // common right shift that brings the largest magnitude below 2^30
  logic [DW-1:0] orv;
  logic [1:0]    sh;
  logic [MW-1:0] m2 [3];
  always_comb begin
    orv = mag1_r[0] | mag1_r[1] | mag1_r[2];
    if (orv[DW-1])      sh = 2'd3;
    else if (orv[DW-2]) sh = 2'd2;
    else if (orv[DW-3]) sh = 2'd1;
    else                sh = 2'd0;
    for (int k = 0; k < 3; k++) begin
      m2[k] = MW'(mag1_r[k] >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      for (int k = 0; k < 3; k++) begin
        sd2_r[k] <= neg1_r[k] ? (SW'(0) - {1'b0, m2[k]}) : {1'b0, m2[k]};
      end
      mx2_r   <= m2[0];
      mz2_r   <= m2[2];
      xzz2_r  <= (m2[0] | m2[2]) == '0;
      deg2_r  <= deg1_r;
      gneg2_r <= gneg1_r;
      a2_r    <= a1_r;
      p2_r    <= PW'(a1_r) * PW'(ave_pkg::GAM_M);
    end
  end

  // reciprocal estimate is exact or one low
  logic [QW-1:0] q0;
  logic [AW-1:0] rem;
  always_comb begin
    q0  = p2_r[ave_pkg::GAM_K +: QW];
    rem = a2_r - AW'(q0) * AW'(ave_pkg::GAM_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      sd3_r   <= sd2_r;
      sqx3_r  <= mx2_r * mx2_r;
      sqz3_r  <= mz2_r * mz2_r;
      deg3_r  <= deg2_r;
      xzz3_r  <= xzz2_r;
      gneg3_r <= gneg2_r;
      q3_r    <= q0 + QW'(rem >= AW'(ave_pkg::GAM_DIV));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
    if (en4) begin
      side4_r.dx      <= sd3_r[0];
      side4_r.dy      <= sd3_r[1];
      side4_r.dz      <= sd3_r[2];
      side4_r.gamma   <= gneg3_r ? ave_pkg::ANGLE_BITS'(QW'(0) - q3_r)
                                 : ave_pkg::ANGLE_BITS'(q3_r);
      side4_r.deg     <= deg3_r;
      side4_r.xz_zero <= xzz3_r;
      sum4_r          <= ave_pkg::SUM_W'(sqx3_r) + ave_pkg::SUM_W'(sqz3_r);
    end
  end

  assign out_valid = v4_r;
  assign out_side  = side4_r;
  assign out_sum   = sum4_r;

endmodule

FILE: rtl/core/ave_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module ave_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ave_pkg::SUM_W-1:0]     in_sum,
  input  ave_pkg::side_t                in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ave_pkg::ROOT_W-1:0]    out_root,
  output ave_pkg::side_t                out_side
);

  localparam int N  = ave_pkg::SQRT_STEPS;
  localparam int VW = ave_pkg::SUM_W;
  localparam int RW = ave_pkg::RES_W;

  logic           v_r   [N];
  logic [VW-1:0]  rem_r [N];
  logic [RW-1:0]  res_r [N];
  ave_pkg::side_t side_r [N];
  logic           en    [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - j));
    logic           v_in;
    logic [VW-1:0]  rem_in;
    logic [RW-1:0]  res_in;
    ave_pkg::side_t side_in;
    logic [RW-1:0]  t;
    logic           ge;
    logic [VW-1:0]  rem_nxt;
    logic [RW-1:0]  res_nxt;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_sum;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign res_in  = res_r[j-1];
      assign side_in = side_r[j-1];
    end

    if (j == N - 1) begin : g_last
      assign en[j] = !v_r[j] || out_ready;
    end else begin : g_mid
      assign en[j] = !v_r[j] || en[j+1];
    end

    always_comb begin
      t  = res_in + BIT;
      ge = {1'b0, rem_in} >= t;
      rem_nxt = ge ? VW'({1'b0, rem_in} - t) : rem_in;
      res_nxt = ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= v_in;
      end
      if (en[j]) begin
        rem_r[j]  <= rem_nxt;
        res_r[j]  <= res_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_root  = res_r[N-1][ave_pkg::ROOT_W-1:0];
  assign out_side  = side_r[N-1];

endmodule

FILE: rtl/core/ave_cordic.sv
// two-lane vectoring cordic: a half-turn pre-rotation stage, then one micro-rotation per stage
`timescale 1ns / 1ps
module ave_cordic #(
  parameter int STAGES = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ave_pkg::CX_W-1:0]   in_y [2],
  input  logic signed [ave_pkg::CX_W-1:0]   in_x [2],
  input  ave_pkg::cside_t                   in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ave_pkg::CZ_W-1:0]   out_z [2],
  output ave_pkg::cside_t                   out_side
);

  localparam int N  = STAGES + 1;
  localparam int XW = ave_pkg::CX_W;
  localparam int ZW = ave_pkg::CZ_W;
  localparam logic signed [ZW-1:0] HALF = ZW'(64'd1 << 31);

  logic                   v_r    [N];
  logic signed [XW-1:0]   x_r    [N][2];
  logic signed [XW-1:0]   y_r    [N][2];
  logic signed [ZW-1:0]   z_r    [N][2];
  ave_pkg::cside_t        side_r [N];
  logic                   en     [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [XW-1:0] x_nxt [2];
    logic signed [XW-1:0] y_nxt [2];
    logic signed [ZW-1:0] z_nxt [2];

    if (k == N - 1) begin : g_last
      assign en[k] = !v_r[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !v_r[k] || en[k+1];
    end

    if (k == 0) begin : g_pre
      // left half plane: rotate by a half turn first
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          if (in_x[l] < 0) begin
            x_nxt[l] = -in_x[l];
            y_nxt[l] = -in_y[l];
            z_nxt[l] = (in_y[l] >= 0) ? HALF : -HALF;
          end else begin
            x_nxt[l] = in_x[l];
            y_nxt[l] = in_y[l];
            z_nxt[l] = '0;
          end
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          v_r[k] <= in_valid;
        end
        if (en[k]) begin
          side_r[k] <= in_side;
        end
      end
    end else begin : g_rot
      localparam int I = k - 1;
      localparam logic signed [ZW-1:0] ANG = ZW'(ave_pkg::atan_tab(5'(I)));
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          if (y_r[k-1][l] >= 0) begin
            x_nxt[l] = x_r[k-1][l] + (y_r[k-1][l] >>> I);
            y_nxt[l] = y_r[k-1][l] - (x_r[k-1][l] >>> I);
            z_nxt[l] = z_r[k-1][l] + ANG;
          end else begin
            x_nxt[l] = x_r[k-1][l] - (y_r[k-1][l] >>> I);
            y_nxt[l] = y_r[k-1][l] + (x_r[k-1][l] >>> I);
            z_nxt[l] = z_r[k-1][l] - ANG;
          end
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
        if (en[k]) begin
          side_r[k] <= side_r[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_r[k] <= x_nxt;
        y_r[k] <= y_nxt;
        z_r[k] <= z_nxt;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_z     = z_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

FILE: rtl/core/aim_vector_to_euler_angles_unit.sv
// aim vector to yxz euler angles, top level
// throughput: one transaction per cycle unless stalled; square root and cordic are fully pipelined
// a stall at the output freezes only the stages holding valid data, bubbles still advance
// reset: synchronous active-low rst_n clears all valid bits and sets beta_sign_mode to 0
`timescale 1ns / 1ps
module aim_vector_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = 18
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_beta_sign_mode,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ave_pkg::COORD_BITS-1:0] in_origin_x,
  input  logic signed [ave_pkg::COORD_BITS-1:0] in_origin_y,
  input  logic signed [ave_pkg::COORD_BITS-1:0] in_origin_z,
  input  logic signed [ave_pkg::COORD_BITS-1:0] in_aim_x,
  input  logic signed [ave_pkg::COORD_BITS-1:0] in_aim_y,
  input  logic signed [ave_pkg::COORD_BITS-1:0] in_aim_z,
  input  logic signed [ave_pkg::ZROT_BITS-1:0]  in_z_rotation,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ave_pkg::ANGLE_BITS-1:0] out_alpha,
  output logic signed [ave_pkg::ANGLE_BITS-1:0] out_beta,
  output logic signed [ave_pkg::ANGLE_BITS-1:0] out_gamma,
  output logic                                  out_degenerate
);

  localparam int AB = ave_pkg::ANGLE_BITS;
  localparam int XW = ave_pkg::CX_W;
  localparam int ZW = ave_pkg::CZ_W;
  localparam int RW = ZW - ave_pkg::ANG_SH;
  localparam logic signed [ZW-1:0] RND = ZW'(1) <<< (ave_pkg::ANG_SH - 1);
  localparam logic signed [RW-1:0] QTR = RW'(1) <<< (AB - 2);

  logic beta_mode_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      beta_mode_r <= cfg_beta_sign_mode;
    end
  end

  logic                           p_valid, p_ready, p_in_ready;
  ave_pkg::side_t                 p_side;
  logic [ave_pkg::SUM_W-1:0]      p_sum;

  ave_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (p_in_ready),
    .origin_x   (in_origin_x),
    .origin_y   (in_origin_y),
    .origin_z   (in_origin_z),
    .aim_x      (in_aim_x),
    .aim_y      (in_aim_y),
    .aim_z      (in_aim_z),
    .z_rotation (in_z_rotation),
    .out_valid  (p_valid),
    .out_ready  (p_ready),
    .out_side   (p_side),
    .out_sum    (p_sum)
  );

  assign in_stall = !p_in_ready;

  logic                        s_valid, s_ready;
  logic [ave_pkg::ROOT_W-1:0]  s_root;
  ave_pkg::side_t              s_side;

  ave_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_sum    (p_sum),
    .in_side   (p_side),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  // lane 0 is alpha = atan2(dx, dz), lane 1 is beta = atan2(+-dy, r)
  logic signed [XW-1:0] c_y [2];
  logic signed [XW-1:0] c_x [2];
  ave_pkg::cside_t      c_side;
  always_comb begin
    c_y[0] = XW'(s_side.dx);
    c_x[0] = XW'(s_side.dz);
    c_y[1] = beta_mode_r ? XW'(s_side.dy) : -XW'(s_side.dy);
    c_x[1] = XW'({1'b0, s_root});
    c_side.gamma   = s_side.gamma;
    c_side.deg     = s_side.deg;
    c_side.xz_zero = s_side.xz_zero;
  end

  logic                 k_valid, k_ready;
  logic signed [ZW-1:0] k_z [2];
  ave_pkg::cside_t      k_side;

  ave_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_y      (c_y),
    .in_x      (c_x),
    .in_side   (c_side),
    .out_valid (k_valid),
    .out_ready (k_ready),
    .out_z     (k_z),
    .out_side  (k_side)
  );

  // output register: round to angle units, wrap alpha, clamp beta, zero all angles of degenerate results
  logic                 out_valid_r;
  logic signed [AB-1:0] alpha_r, beta_r, gamma_r;
  logic                 deg_r;
  logic signed [ZW-1:0] za_s, zb_s;
  logic signed [RW-1:0] ra, rb;
  logic signed [AB-1:0] alpha_nxt, beta_nxt, gamma_nxt;

  assign k_ready = !out_valid_r || !out_stall;

  always_comb begin
    za_s = (k_z[0] + RND) >>> ave_pkg::ANG_SH;
    zb_s = (k_z[1] + RND) >>> ave_pkg::ANG_SH;
    ra   = za_s[RW-1:0];
    rb   = zb_s[RW-1:0];
    alpha_nxt = k_side.xz_zero ? '0 : ra[AB-1:0];
    if (rb > QTR)       beta_nxt = QTR[AB-1:0];
    else if (rb < -QTR) beta_nxt = AB'(-QTR);
    else                beta_nxt = rb[AB-1:0];
    gamma_nxt = k_side.gamma;
    if (k_side.deg) begin
      alpha_nxt = '0;
      beta_nxt  = '0;
      gamma_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (k_ready) begin
      out_valid_r <= k_valid;
    end
    if (k_ready) begin
      alpha_r <= alpha_nxt;
      beta_r  <= beta_nxt;
      gamma_r <= gamma_nxt;
      deg_r   <= k_side.deg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alpha      = alpha_r;
  assign out_beta       = beta_r;
  assign out_gamma      = gamma_r;
  assign out_degenerate = deg_r;

endmodule

FILE: rtl/core/ave_checker.sv
// port-level checks for the aim vector angle unit, bound to the top level
`timescale 1ns / 1ps
module ave_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [ave_pkg::ANGLE_BITS-1:0] out_alpha,
  input logic signed [ave_pkg::ANGLE_BITS-1:0] out_beta,
  input logic signed [ave_pkg::ANGLE_BITS-1:0] out_gamma,
  input logic                                  out_degenerate
);

  localparam logic signed [ave_pkg::ANGLE_BITS-1:0] QTR =
    ave_pkg::ANGLE_BITS'(1) <<< (ave_pkg::ANGLE_BITS - 2);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alpha) && $stable(out_beta)
      && $stable(out_gamma) && $stable(out_degenerate))
    else $error("stalled result changed");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_alpha == '0 && out_beta == '0 && out_gamma == '0)
    else $error("degenerate result with nonzero angle");

  a_beta_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beta <= QTR) && (out_beta >= -QTR))
    else $error("beta beyond a quarter turn");

endmodule

bind aim_vector_to_euler_angles_unit ave_checker u_ave_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_alpha      (out_alpha),
  .out_beta       (out_beta),
  .out_gamma      (out_gamma),
  .out_degenerate (out_degenerate)
);
